/* rtl/core/sitda_pkg.sv */
// sitda_pkg: shared types and constants for the integer to decimal text block
// stage payload struct, power-of-ten table and character codes
// no dependencies
package sitda_pkg;

   localparam int unsigned DIGIT_COUNT = 10;
   localparam logic [3:0]  LAST_POS    = 4'd9;
   localparam logic [7:0]  CHAR_MINUS  = 8'd45;
   localparam logic [7:0]  CHAR_ZERO   = 8'd48;

   localparam logic [31:0] POW10 [DIGIT_COUNT] = '{
      32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
      32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
   };

   typedef logic [3:0] digit_type;

   // digits[0] is the most significant decimal place
   typedef struct packed {
      logic                             neg;
      logic [31:0]                      mag;
      digit_type [DIGIT_COUNT-1:0]      digits;
   } stage_type;

endpackage

/* rtl/core/sitda_cell.sv */
// sitda_cell: one digit cell of the conversion chain
// takes one decimal place off the remaining magnitude and passes it on
// depends on sitda_pkg
module sitda_cell import sitda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] pos,
   input  logic       up_valid,
   output logic       up_ready,
   input  stage_type  up_data,
   output logic       dn_valid,
   input  logic       dn_ready,
   output stage_type  dn_data
);

   logic      valid_ff, valid_in;
   stage_type data_ff, data_in;
   stage_type result;
   logic [33:0] pow;
   logic [33:0] mult;
   logic [33:0] sub;
   digit_type   digit;

   // digit is the largest multiple of the place value that fits
   always_comb begin
      pow   = {2'b00, POW10[pos]};
      mult  = '0;
      sub   = '0;
      digit = '0;
      for (int k = 1; k <= 9; k++) begin
         mult = pow * 34'(k);
         if ({2'b00, up_data.mag} >= mult) begin
            digit = 4'(k);
            sub   = mult;
         end
      end
      result             = up_data;
      result.mag         = 32'({2'b00, up_data.mag} - sub);
      result.digits[pos] = digit;
   end

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (up_ready) begin
         valid_in = up_valid;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

/* rtl/core/sitda_emit.sv */
// sitda_emit: character sequencer at the end of the digit chain
// sends the sign and the significant digits, one beat per character
// depends on sitda_pkg
module sitda_emit import sitda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  stage_type  up_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_character,
   output logic       rsp_last
);

   logic busy_ff, busy_in;
   logic sign_ff, sign_in;
   logic [3:0] pos_ff, pos_in;
   digit_type [DIGIT_COUNT-1:0] digits_ff, digits_in;
   logic [3:0] lead;
   logic       found;
   logic       load;
   logic       done;

   // first significant place, units place when the value is zero
   always_comb begin
      lead  = LAST_POS;
      found = 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (!found && up_data.digits[i] != 4'd0) begin
            lead  = 4'(i);
            found = 1'b1;
         end
      end
   end

   assign rsp_valid     = busy_ff;
   assign rsp_last      = !sign_ff && pos_ff == LAST_POS;
   assign rsp_character = sign_ff ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digits_ff[pos_ff]});

   assign done     = busy_ff && rsp_ready && rsp_last;
   assign up_ready = !busy_ff || done;
   assign load     = up_valid && up_ready;

   always_comb begin
      busy_in   = busy_ff;
      sign_in   = sign_ff;
      pos_in    = pos_ff;
      digits_in = digits_ff;
      if (load) begin
         busy_in   = 1'b1;
         sign_in   = up_data.neg;
         pos_in    = lead;
         digits_in = up_data.digits;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sign_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sign_ff <= sign_in;
         pos_ff  <= pos_in;
      end
      digits_ff <= digits_in;
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff <= LAST_POS)
      else $error("character position beyond units place");

   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      (load && up_data.neg) |=> (busy_ff && sign_ff))
      else $error("minus sign not sent first");

   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      load |=> (digits_ff[pos_ff] != 4'd0 || pos_ff == LAST_POS))
      else $error("leading zero not suppressed");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_ready) |=> ($stable(pos_ff) && $stable(sign_ff) && busy_ff))
      else $error("sequencer moved during stall");

endmodule

/* rtl/core/signed_int_to_decimal_ascii_top.sv */
// Converts a signed 32-bit integer to its decimal text: an optional minus
// sign, then the significant digits from the most significant down, one
// character per result beat, with rsp_last on the final one. Zero gives "0".
// A number gives 1 to 11 characters, and a new number is taken every
// cycle while the ten-cell digit chain has room; the single character
// port sets the sustained rate. The first character is offered once the
// number has passed the ten registered digit cells and then the character
// sequencer.
// depends on sitda_pkg, sitda_cell, sitda_emit
module signed_int_to_decimal_ascii_top import sitda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   logic      chain_valid [DIGIT_COUNT+1];
   logic      chain_ready [DIGIT_COUNT+1];
   stage_type chain_data  [DIGIT_COUNT+1];
   logic [31:0] req_mag;

   // magnitude in unsigned arithmetic so the most negative value works
   assign req_mag       = req_value[31] ? (32'd0 - req_value) : req_value;
   assign chain_data[0] = '{neg: req_value[31], mag: req_mag, digits: '0};

   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0];

   for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
      sitda_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .pos      (4'(g)),
         .up_valid (chain_valid[g]),
         .up_ready (chain_ready[g]),
         .up_data  (chain_data[g]),
         .dn_valid (chain_valid[g+1]),
         .dn_ready (chain_ready[g+1]),
         .dn_data  (chain_data[g+1])
      );
   end

   sitda_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (chain_valid[DIGIT_COUNT]),
      .up_ready      (chain_ready[DIGIT_COUNT]),
      .up_data       (chain_data[DIGIT_COUNT]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
